[design/sfr_pkg.sv]
`default_nettype none

package sfr_pkg;

	localparam int MAX_PATTERN_DEF     = 8;
	localparam int MAX_REPLACEMENT_DEF = 8;
	localparam int CFG_W               = 64;
	localparam int LEN_W               = 4;

	typedef logic [7:0] byte_t;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

endpackage

`default_nettype wire

[design/stream_find_replace.sv]
// Flow: a byte accepted at the input is registered in the input stage, evaluated against the window
// once the output buffer can take its results, and its first result is offered from the output buffer.
// Throughput: one input beat per cycle while each item yields at most one result and out_ready is
// high; an item that yields several results holds the input stage until its last result is taken.
// Reset (arst_n low, asynchronous): window empty, no item in flight, pattern length one,
// pattern, replacement and replacement length zero.
`default_nettype none

module stream_find_replace #(
	parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
	parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,

	input  wire logic                    cfg_write,
	input  wire sfr_pkg::cfg_reg_t       cfg_index,
	input  wire logic [sfr_pkg::CFG_W-1:0] cfg_data,

	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [7:0]              text_byte,
	input  wire logic                    text_end,

	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [7:0]                   out_byte,
	output logic                         byte_present,
	output logic                         out_end
);
	import sfr_pkg::*;

	localparam int RES_DEPTH = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int CNT_W     = $clog2(MAX_PATTERN + 1);
	localparam int RCNT_W    = $clog2(MAX_REPLACEMENT + 1);
	localparam int NUM_W     = $clog2(RES_DEPTH + 1);

	// Configuration registers.
	logic [CFG_W-1:0] pattern_bytes_q;
	logic [LEN_W-1:0] pattern_length_q;
	logic [CFG_W-1:0] replacement_bytes_q;
	logic [LEN_W-1:0] replacement_length_q;

	// Input stage.
	logic             valid_s1;
	byte_t            byte_s1;
	logic             end_s1;

	// Window state.
	byte_t            win_q [MAX_PATTERN];
	logic [CNT_W-1:0] held_q;
	logic [CNT_W-1:0] active_len_q;

	// Output buffer: results leave from entry zero, the rest shift down.
	byte_t            res_q [RES_DEPTH];
	logic [NUM_W-1:0] num_q;
	logic             present_q;
	logic             end_q;

	logic             out_take;
	logic             buf_free;
	logic             go;

	logic [CNT_W-1:0]  eff_plen;
	logic [RCNT_W-1:0] eff_rlen;
	logic [CNT_W-1:0]  alen;
	logic [CNT_W-1:0]  cnt1;
	byte_t             win_n [MAX_PATTERN];
	byte_t             win_d [MAX_PATTERN];
	logic              full;
	logic              match;
	logic              hit;
	logic [CNT_W-1:0]  held_d;
	byte_t             res_d [RES_DEPTH];
	logic [NUM_W-1:0]  num_d;
	logic              present_d;

	assign out_valid    = (num_q != '0);
	assign out_take     = out_valid && out_ready;
	assign buf_free     = (num_q == '0) || ((num_q == NUM_W'(1)) && out_take);
	assign go           = valid_s1 && buf_free;
	assign in_ready     = !valid_s1 || buf_free;

	assign out_byte     = res_q[0];
	assign byte_present = present_q;
	assign out_end      = end_q && (num_q == NUM_W'(1));

	always_comb begin
		if (pattern_length_q == '0) begin
			eff_plen = CNT_W'(1);
		end else if (pattern_length_q > LEN_W'(MAX_PATTERN)) begin
			eff_plen = CNT_W'(MAX_PATTERN);
		end else begin
			eff_plen = CNT_W'(pattern_length_q);
		end
		if (replacement_length_q > LEN_W'(MAX_REPLACEMENT)) begin
			eff_rlen = RCNT_W'(MAX_REPLACEMENT);
		end else begin
			eff_rlen = RCNT_W'(replacement_length_q);
		end
	end

	always_comb begin
		// The pattern length is latched only while the window is empty.
		alen = (held_q == '0) ? eff_plen : active_len_q;
		cnt1 = held_q + CNT_W'(1);

		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_n[i] = (held_q == CNT_W'(i)) ? byte_s1 : win_q[i];
		end

		full  = (cnt1 >= alen);
		match = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if ((CNT_W'(i) < alen) && (win_n[i] != pattern_bytes_q[8*i +: 8])) begin
				match = 1'b0;
			end
		end
		hit = full && match;

		// A full window that misses passes its oldest byte and slides by one.
		win_d = win_n;
		if (full && !match) begin
			for (int i = 0; i < MAX_PATTERN - 1; i++) begin
				win_d[i] = win_n[i + 1];
			end
		end

		if (end_s1 || hit) begin
			held_d = '0;
		end else if (full) begin
			held_d = held_q;
		end else begin
			held_d = cnt1;
		end

		for (int i = 0; i < RES_DEPTH; i++) begin
			res_d[i] = '0;
		end
		present_d = 1'b1;
		if (hit) begin
			for (int i = 0; i < MAX_REPLACEMENT; i++) begin
				res_d[i] = replacement_bytes_q[8*i +: 8];
			end
			num_d = NUM_W'(eff_rlen);
		end else begin
			// On the final byte the oldest byte and the rest of the window leave together.
			for (int i = 0; i < MAX_PATTERN; i++) begin
				res_d[i] = win_n[i];
			end
			if (end_s1) begin
				num_d = NUM_W'(cnt1);
			end else if (full) begin
				num_d = NUM_W'(1);
			end else begin
				num_d = '0;
			end
		end

		// A text that ends with nothing left to send still gets one empty beat.
		if (end_s1 && (num_d == '0)) begin
			num_d     = NUM_W'(1);
			present_d = 1'b0;
			res_d[0]  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_bytes_q      <= '0;
			pattern_length_q     <= LEN_W'(1);
			replacement_bytes_q  <= '0;
			replacement_length_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PATTERN_BYTES:      pattern_bytes_q      <= cfg_data;
				REG_PATTERN_LENGTH:     pattern_length_q     <= cfg_data[LEN_W-1:0];
				REG_REPLACEMENT_BYTES:  replacement_bytes_q  <= cfg_data;
				REG_REPLACEMENT_LENGTH: replacement_length_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			held_q       <= '0;
			active_len_q <= CNT_W'(1);
			num_q        <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				held_q       <= held_d;
				active_len_q <= alen;
				num_q        <= num_d;
			end else if (out_take) begin
				num_q <= num_q - NUM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= text_byte;
			end_s1  <= text_end;
		end
		if (go) begin
			win_q     <= win_d;
			res_q     <= res_d;
			present_q <= present_d;
			end_q     <= end_s1;
		end else if (out_take) begin
			for (int i = 0; i < RES_DEPTH - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

	// The window never holds a full pattern's worth of bytes between items.
	a_held_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0) || (held_q < active_len_q))
		else $error("held byte count reached the pattern length");

	a_num_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		num_q <= NUM_W'(RES_DEPTH))
		else $error("output buffer count out of range");

	// The final byte of a text always leaves at least one beat behind it.
	a_end_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(go && end_s1) |=> (out_valid && end_q && (held_q == '0)))
		else $error("final byte produced no closing beat");

	a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid))
		else $error("input stalled with an idle pipeline");

	a_drain_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && !go) |=> (num_q == $past(num_q) - NUM_W'(1)))
		else $error("output buffer did not drain by one beat");

endmodule

`default_nettype wire
